@@ rtl/core/sha256_hash_macros.svh @@
// assertion macros for the sha256 hash block
`ifndef SHA256_HASH_MACROS_SVH
`define SHA256_HASH_MACROS_SVH
// assert that a condition implies a consequence on the same edge
`define SHA_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");
// assert that a condition implies a consequence on the next edge
`define SHA_ASSERT_NXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/sha_pkg.sv @@
// shared types, constants and functions of the sha256 hash block
`default_nettype none
package sha_pkg;
  typedef logic [31:0] word_t;

  // one word for the compression back end
  typedef struct packed {
    word_t      data;
    logic       flush;  // last word of the message block sequence
  } qword_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t init_h(input logic [2:0] i);
    init_h = InitH[(7 - i) * 32 +: 32];
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    round_k = k[i];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/sha_front.sv @@
// front end: byte counting and padding, emits a stream of block words
`default_nettype none
module sha_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [31:0]    data_word_i,
  input  wire logic [2:0]     valid_bytes_i,
  input  wire logic           final_word_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output sha_pkg::qword_t     word_o,
  output logic                word_valid_o,
  input  wire logic           word_ready_i
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    FeIn  = 3'b001,
    FePad = 3'b010,
    FeLen = 3'b100
  } fe_state_e;

  fe_state_e   state_q, state_d;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] bytes_q, bytes_d;
  logic        mark_q, mark_d;   // marker word still owed
  logic        lo_q, lo_d;       // low length word next
  logic [2:0]  nb;
  logic [63:0] bits;
  word_t       kept;

  assign nb   = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
  assign bits = {bytes_q[60:0], 3'b000};

  always_comb begin
    case (nb)
      3'd0:    kept = 32'h8000_0000;
      3'd1:    kept = {data_word_i[31:24], 24'h80_0000};
      3'd2:    kept = {data_word_i[31:16], 16'h8000};
      3'd3:    kept = {data_word_i[31:8], 8'h80};
      default: kept = data_word_i;
    endcase
  end

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    bytes_d = bytes_q;
    mark_d = mark_q;
    lo_d = lo_q;
    in_ready_o = 1'b0;
    word_valid_o = 1'b0;
    word_o.data = data_word_i;
    word_o.flush = 1'b0;
    case (state_q)
      FeIn: begin
        in_ready_o = word_ready_i;
        word_valid_o = in_valid_i;
        if (final_word_i) begin
          word_o.data = kept;
        end
        if (in_valid_i && word_ready_i) begin
          pos_d = pos_q + 4'd1;
          if (!final_word_i) begin
            bytes_d = bytes_q + 64'd4;
          end else begin
            bytes_d = bytes_q + {61'd0, nb};
            mark_d = (nb == 3'd4);
            state_d = FePad;
          end
        end
      end
      FePad: begin
        word_valid_o = 1'b1;
        word_o.data = mark_q ? 32'h8000_0000 : 32'd0;
        if (pos_q == 4'd14 && !mark_q) begin
          word_valid_o = 1'b0;
          state_d = FeLen;
          lo_d = 1'b0;
        end else if (word_ready_i) begin
          mark_d = 1'b0;
          pos_d = pos_q + 4'd1;
        end
      end
      FeLen: begin
        word_valid_o = 1'b1;
        word_o.data = lo_q ? bits[31:0] : bits[63:32];
        word_o.flush = lo_q;
        if (word_ready_i) begin
          pos_d = pos_q + 4'd1;
          lo_d = 1'b1;
          if (lo_q) begin
            state_d = FeIn;
            bytes_d = '0;
            pos_d = '0;
          end
        end
      end
      default: state_d = FeIn;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIn;
      pos_q <= '0;
      bytes_q <= '0;
      mark_q <= 1'b0;
      lo_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      bytes_q <= bytes_d;
      mark_q <= mark_d;
      lo_q <= lo_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/sha_queue.sv @@
// short word queue between front and back end
`default_nettype none
module sha_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  sha_pkg::qword_t  wr_data_i,
  input  wire logic        wr_valid_i,
  output logic             wr_ready_o,
  output sha_pkg::qword_t  rd_data_o,
  output logic             rd_valid_o,
  input  wire logic        rd_ready_i
);
  import sha_pkg::*;

  qword_t         mem_q [QDepth];
  logic [QAw:0]   wp_q, rp_q;
  logic           wr, rd;

  assign wr_ready_o = (wp_q - rp_q) != (QAw + 1)'(QDepth);
  assign rd_valid_o = wp_q != rp_q;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q[QAw-1:0]];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q[QAw-1:0]] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/sha_core.sv @@
// back end: block buffer, 64-round compression and digest output
`default_nettype none
module sha_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  sha_pkg::qword_t  word_i,
  input  wire logic        word_valid_i,
  output logic             word_ready_o,
  output logic [31:0]      digest_o,
  output logic [2:0]       index_o,
  output logic             last_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    BkLoad = 4'b0001,
    BkRound = 4'b0010,
    BkAdd  = 4'b0100,
    BkOut  = 4'b1000
  } bk_state_e;

  bk_state_e   state_q;
  word_t       w_q [16];
  word_t       h_q [8];
  word_t       a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
  logic [3:0]  cnt_q;
  logic [5:0]  rnd_q;
  logic        fin_q;
  logic [2:0]  oi_q;
  word_t       s0, s1, wnew, t1, t2;

  assign word_ready_o = (state_q == BkLoad);
  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = s1 + w_q[9] + s0 + w_q[0];
  assign t1 = hh_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25))
            + (g_q ^ (e_q & (f_q ^ g_q))) + round_k(rnd_q) + w_q[0];
  assign t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22))
            + ((a_q & b_q) | (c_q & (a_q | b_q)));

  assign digest_o = h_q[oi_q];
  assign index_o = oi_q;
  assign last_o = (oi_q == 3'd7);
  assign out_valid_o = (state_q == BkOut);

  // message schedule window, shifted one per loaded word and one per round
  always_ff @(posedge clk_i) begin
    if (state_q == BkLoad && word_valid_i) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= word_i.data;
    end else if (state_q == BkRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      a_q <= t1 + t2; b_q <= a_q; c_q <= b_q; d_q <= c_q;
      e_q <= d_q + t1; f_q <= e_q; g_q <= f_q; hh_q <= g_q;
    end
    if (state_q == BkLoad && word_valid_i && cnt_q == 4'd15) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
      e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkLoad;
      cnt_q <= '0;
      rnd_q <= '0;
      fin_q <= 1'b0;
      oi_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      case (state_q)
        BkLoad: begin
          if (word_valid_i) begin
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q == 4'd15) begin
              fin_q <= word_i.flush;
              rnd_q <= '0;
              state_q <= BkRound;
            end
          end
        end
        BkRound: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= BkAdd;
        end
        BkAdd: begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
          h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
          oi_q <= '0;
          state_q <= fin_q ? BkOut : BkLoad;
        end
        BkOut: begin
          if (out_ready_i) begin
            oi_q <= oi_q + 3'd1;
            if (oi_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
              state_q <= BkLoad;
            end
          end
        end
        default: state_q <= BkLoad;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/sha256_hash.sv @@
// SHA-256 hasher over a stream of 32-bit big-endian message words
//
// slave channel s_axis: one request per message word; tdata holds the word,
// tuser the count of valid leading bytes (0..4, only the last word may be
// short) and tlast marks the final word of a message.
// master channel m_axis: eight digest words after each message, H0 first;
// tuser carries the word index and tlast is high on the eighth word.
// a front end counts bytes and inserts padding and the bit length; a
// four-entry queue feeds the compression core, which loads 16 words and then
// runs one round per cycle through the 64 rounds, then the chaining add.
// the core takes no new words while it compresses a block or offers a digest;
// the first digest word is offered once the last block's chaining add is done.
// reset restores the initial chaining values and clears all counters.
// a stalled master channel holds the digest word; the queue and front end
// keep taking words until the queue fills, then s_axis_tready falls.
`default_nettype none
`include "sha256_hash_macros.svh"
module sha256_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // data_word
  input  wire logic [2:0]  s_axis_tuser,   // valid_bytes
  input  wire logic        s_axis_tlast,   // final_word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // digest_word
  output logic [2:0]       m_axis_tuser,   // word_index
  output logic             m_axis_tlast    // last_of_digest
);
  import sha_pkg::*;

  qword_t fw, qw;
  logic   fw_valid, fw_ready, qw_valid, qw_ready;

  sha_front u_front (
    .clk_i, .rst_ni,
    .data_word_i(s_axis_tdata), .valid_bytes_i(s_axis_tuser),
    .final_word_i(s_axis_tlast), .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .word_o(fw), .word_valid_o(fw_valid), .word_ready_i(fw_ready)
  );

  sha_queue u_queue (
    .clk_i, .rst_ni,
    .wr_data_i(fw), .wr_valid_i(fw_valid), .wr_ready_o(fw_ready),
    .rd_data_o(qw), .rd_valid_o(qw_valid), .rd_ready_i(qw_ready)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .word_i(qw), .word_valid_i(qw_valid), .word_ready_o(qw_ready),
    .digest_o(m_axis_tdata), .index_o(m_axis_tuser), .last_o(m_axis_tlast),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready)
  );

  `SHA_ASSERT_IMP(a_last_idx, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
                  m_axis_tuser == 3'd7)
  `SHA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tuser))
  `SHA_ASSERT_IMP(a_no_load_out, clk_i, rst_ni, m_axis_tvalid, !qw_ready)
endmodule
`default_nettype wire

@@ tb/sv/tb_sha256_hash.sv @@
// testbench for the sha256 hash block: streamed messages checked against a digest predictor
`default_nettype none
module tb_sha256_hash;
  import sha_pkg::*;

  localparam int unsigned StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  always #6 clk_i = ~clk_i;

  sha256_hash dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_of_digest;
  } digest_t;

  class digest_scoreboard;
    word_t       chain[8];
    word_t       blk[16];
    int unsigned fill;
    logic [63:0] msg_bytes;
    digest_t     pending[$];
    int unsigned mismatches;
    int unsigned digests_seen;
    int unsigned words_taken;

    function new();
      restart();
      mismatches = 0;
      digests_seen = 0;
      words_taken = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = InitH[(7 - i) * 32 +: 32];
      fill = 0;
      msg_bytes = '0;
    endfunction

    function word_t ror(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      word_t w[64];
      word_t a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++)
        w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
             + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + (g ^ (e & (f ^ g)))
           + round_k(6'(i)) + w[i];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) | (c & (a | b)));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void put(word_t x);
      blk[fill] = x;
      fill++;
      if (fill == 16) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_request(word_t data, logic [2:0] nb, logic fin);
      logic [63:0] bits;
      int unsigned n;
      words_taken++;
      if (!fin) begin
        msg_bytes += 4;
        put(data);
        return;
      end
      n = (nb > 4) ? 4 : nb;
      msg_bytes += n;
      bits = msg_bytes << 3;
      if (n == 4) begin
        put(data);
        put(32'h8000_0000);
      end else begin
        put((n == 0 ? 32'h0 : data & ~(32'hffff_ffff >> (8 * n)))
            | (32'h8000_0000 >> (8 * n)));
      end
      if (fill > 14) while (fill != 0) put('0);
      while (fill < 14) put('0);
      put(bits[63:32]);
      put(bits[31:0]);
      for (int i = 0; i < 8; i++) pending.push_back({chain[i], 3'(i), i == 7});
      restart();
    endfunction

    function void check_digest(digest_t got);
      digest_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h idx %0d", got.digest_word,
                                       got.word_index);
        return;
      end
      exp = pending.pop_front();
      if (exp.last_of_digest) digests_seen++;
      if (exp !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp word %h idx %0d last %b, got word %h idx %0d last %b",
                   exp.digest_word, exp.word_index, exp.last_of_digest,
                   got.digest_word, got.word_index, got.last_of_digest);
      end
    endfunction
  endclass

  digest_scoreboard sb = new();
  int unsigned src_idle = 0;
  int unsigned snk_idle = 0;
  int unsigned quiet_cycles = 0;

  // receiver and request monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_digest({m_axis_tdata, m_axis_tuser, m_axis_tlast});
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays high after a request so the next one can follow back to back
  task automatic send_word(word_t data, logic [2:0] nb, logic fin);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= nb;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // random message: mostly short, body words marked full but for a rare malformed count
  task automatic send_message(int unsigned body);
    for (int i = 0; i < body; i++) begin
      // rare malformed byte count on a body word
      send_word($urandom, ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0);
    end
    send_word($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  int unsigned sent;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, every final byte count, extremes and block boundaries
    for (int nb = 0; nb < 8; nb++) send_word(nb[0] ? 32'hffff_ffff : 32'h0, 3'(nb), 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);  // "abc"
    for (int i = 0; i < 13; i++) send_word(32'hffff_ffff, 3'd4, 1'b0);
    send_word(32'h0, 3'd0, 1'b1);          // marker lands at position 13
    drain();  // sender holds off until all digests are out
    for (int i = 0; i < 14; i++) send_word(32'ha5a5_5a5a, 3'd2, 1'b0);
    send_word(32'h1234_5678, 3'd1, 1'b1);  // marker at 14, length needs a fresh block
    for (int i = 0; i < 15; i++) send_word($urandom, 3'd4, 1'b0);
    send_word(32'hdead_beef, 3'd4, 1'b1);  // marker word opens a new block

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 35 : (ph == 1) ? 64 : 0;
      snk_idle = (ph == 0) ? 64 : (ph == 1) ? 35 : 0;
      sent = sb.words_taken;
      while (sb.words_taken - sent < 20)
        send_message(($urandom_range(9) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 5));
    end

    drain();
    $display("hashed %0d digests from %0d words under mixed back-pressure",
             sb.digests_seen, sb.words_taken);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
